// ----- rtl/core/i8mac_pkg.sv -----
package i8mac_pkg;

  // Activation FIFO geometry
  localparam int FifoDepth = 8;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);

  // Configuration register file
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SKIP_ENABLE = 2'd0,
    CFG_SKIP_THRESH = 2'd1,
    CFG_CLOCK_GATE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MODE_PUSH       = 4'd0,
    MODE_POP        = 4'd1,
    MODE_LOAD_W     = 4'd2,
    MODE_LOAD_PAIR  = 4'd3,
    MODE_SWAP       = 4'd4,
    MODE_MAC_FIFO   = 4'd5,
    MODE_MAC_DIRECT = 4'd6,
    MODE_WRITE_ACC  = 4'd7,
    MODE_CLEAR_ACC  = 4'd8,
    MODE_RESET      = 4'd9
  } mode_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic signed [7:0]  act_value;
    logic signed [7:0]  weight_a;
    logic signed [7:0]  weight_b;
    logic               skip_test;
    logic signed [31:0] acc_value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] acc_out;
    logic               step_overflow;
    logic               step_underflow;
    logic               sticky_overflow;
    logic               skipped;
    logic               bubble;
    logic signed [7:0]  popped_value;
    logic [CntW-1:0]    fifo_fill;
    logic               low_fill;
    logic               high_fill;
    logic               weight_ready;
    logic               computing;
  } res_t;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic              skip_enable;
    logic signed [7:0] skip_threshold;
    logic              clock_gate;
  } cfg_t;

endpackage

// ----- rtl/core/i8mac_in_reg.sv -----
module i8mac_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  i8mac_pkg::cmd_t in_data,
  input  logic          advance,
  output logic          cmd_valid,
  output i8mac_pkg::cmd_t cmd
);
  import i8mac_pkg::*;

  // Take a new command when empty or when the held one moves on this cycle
  assign in_ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_data;
    end
  end

endmodule

// ----- rtl/core/i8mac_core.sv -----
module i8mac_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  i8mac_pkg::cmd_t cmd,
  input  logic            cfg_we,
  input  logic [i8mac_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [i8mac_pkg::CfgDataW-1:0] cfg_data,
  output i8mac_pkg::res_t res
);
  import i8mac_pkg::*;

  // Architectural state
  cfg_t               cfg;
  logic signed [31:0] accumulator;
  logic               overflow_seen;
  logic               compute_mode;
  logic signed [7:0]  act_store [FifoDepth];
  logic [PtrW-1:0]    read_ptr;
  logic [PtrW-1:0]    write_ptr;
  logic [CntW-1:0]    act_count;
  logic               low_fill_flag;
  logic               high_fill_flag;
  logic signed [7:0]  weight_banks [2];
  logic [1:0]         bank_valid;
  logic               selected_bank;

  logic signed [31:0] accumulator_next;
  logic               overflow_seen_next;
  logic               compute_mode_next;
  logic [PtrW-1:0]    read_ptr_next;
  logic [PtrW-1:0]    write_ptr_next;
  logic [CntW-1:0]    act_count_next;
  logic               low_fill_flag_next;
  logic               high_fill_flag_next;
  logic signed [7:0]  bank0_next;
  logic signed [7:0]  bank1_next;
  logic [1:0]         bank_valid_next;
  logic               selected_bank_next;
  logic               clock_gate_next;
  logic               push_en;

  // MAC datapath
  logic               is_mac;
  logic signed [7:0]  mac_a;
  logic signed [7:0]  mac_w;
  logic               mac_check;
  logic signed [8:0]  thr9;
  logic signed [8:0]  neg_thr9;
  logic signed [8:0]  a9;
  logic               in_band;
  logic               mac_idle;
  logic               mac_skip;
  logic signed [15:0] product;
  logic signed [32:0] sum33;
  logic               sum_ovf;
  logic               sum_unf;
  logic signed [7:0]  head;

  assign head = act_store[read_ptr];

  always_comb begin
    mac_a     = 8'sd0;
    mac_w     = 8'sd0;
    mac_check = 1'b0;
    is_mac    = 1'b0;
    case (cmd.mode)
      MODE_MAC_FIFO: begin
        is_mac    = 1'b1;
        mac_a     = (act_count != '0) ? head : 8'sd0;
        mac_w     = bank_valid[selected_bank] ? weight_banks[selected_bank] : 8'sd0;
        mac_check = cmd.skip_test;
      end
      MODE_MAC_DIRECT: begin
        is_mac    = 1'b1;
        mac_a     = cmd.act_value;
        mac_w     = cmd.weight_a;
        mac_check = 1'b1;
      end
      default: begin
        is_mac = 1'b0;
      end
    endcase
  end

  // Skip band is open: -thr < a < thr, plus exact zero
  assign thr9     = 9'(cfg.skip_threshold);
  assign neg_thr9 = -thr9;
  assign a9       = 9'(mac_a);
  assign in_band  = (mac_a == 8'sd0) ||
                    ((thr9 != 9'sd0) && (a9 < thr9) && (a9 > neg_thr9));
  assign mac_idle = cfg.clock_gate || !compute_mode;
  assign mac_skip = !mac_idle && mac_check && cfg.skip_enable && in_band;

  assign product = mac_a * mac_w;
  assign sum33   = 33'(accumulator) + 33'(product);
  assign sum_ovf = !sum33[32] && sum33[31];
  assign sum_unf = sum33[32] && !sum33[31];

  always_comb begin
    accumulator_next    = accumulator;
    overflow_seen_next  = overflow_seen;
    compute_mode_next   = compute_mode;
    read_ptr_next       = read_ptr;
    write_ptr_next      = write_ptr;
    act_count_next      = act_count;
    low_fill_flag_next  = low_fill_flag;
    high_fill_flag_next = high_fill_flag;
    bank0_next          = weight_banks[0];
    bank1_next          = weight_banks[1];
    bank_valid_next     = bank_valid;
    selected_bank_next  = selected_bank;
    clock_gate_next     = cfg.clock_gate;
    push_en             = 1'b0;

    res                 = '0;

    case (cmd.mode)
      MODE_PUSH: begin
        if (act_count < CntW'(FifoDepth)) begin
          push_en        = 1'b1;
          write_ptr_next = (write_ptr == PtrW'(FifoDepth - 1)) ? '0 : write_ptr + 1'b1;
          act_count_next = act_count + 1'b1;
          low_fill_flag_next  = (act_count_next <= CntW'(2));
          high_fill_flag_next = (act_count_next >= CntW'(FifoDepth - 2));
        end
      end
      MODE_POP: begin
        if (act_count != '0) begin
          res.popped_value = head;
          read_ptr_next  = (read_ptr == PtrW'(FifoDepth - 1)) ? '0 : read_ptr + 1'b1;
          act_count_next = act_count - 1'b1;
          low_fill_flag_next  = (act_count_next <= CntW'(2));
          high_fill_flag_next = (act_count_next >= CntW'(FifoDepth - 2));
        end
      end
      MODE_LOAD_W: begin
        if (selected_bank) begin
          bank1_next = cmd.weight_a;
        end else begin
          bank0_next = cmd.weight_a;
        end
        bank_valid_next[selected_bank] = 1'b1;
        compute_mode_next = 1'b1;
      end
      MODE_LOAD_PAIR: begin
        bank0_next         = cmd.weight_a;
        bank1_next         = cmd.weight_b;
        bank_valid_next    = 2'b11;
        selected_bank_next = 1'b0;
        compute_mode_next  = 1'b1;
      end
      MODE_SWAP: begin
        selected_bank_next = !selected_bank;
      end
      MODE_WRITE_ACC: begin
        accumulator_next = cmd.acc_value;
      end
      MODE_CLEAR_ACC: begin
        accumulator_next = '0;
      end
      MODE_RESET: begin
        accumulator_next    = '0;
        overflow_seen_next  = 1'b0;
        compute_mode_next   = 1'b0;
        read_ptr_next       = '0;
        write_ptr_next      = '0;
        act_count_next      = '0;
        low_fill_flag_next  = 1'b0;
        high_fill_flag_next = 1'b0;
        bank0_next          = '0;
        bank1_next          = '0;
        bank_valid_next     = '0;
        selected_bank_next  = 1'b0;
        clock_gate_next     = 1'b0;
      end
      default: begin
        // MAC modes handled below; undefined modes change nothing
      end
    endcase

    if (is_mac) begin
      if (mac_idle || mac_skip) begin
        res.bubble  = 1'b1;
        res.skipped = mac_skip;
      end else begin
        res.step_overflow  = sum_ovf;
        res.step_underflow = sum_unf;
        overflow_seen_next = overflow_seen || sum_ovf || sum_unf;
        accumulator_next   = sum33[31:0];
      end
    end

    res.acc_out         = accumulator_next;
    res.sticky_overflow = overflow_seen_next;
    res.fifo_fill       = act_count_next;
    res.low_fill        = low_fill_flag_next;
    res.high_fill       = high_fill_flag_next;
    res.weight_ready    = bank_valid_next[selected_bank_next];
    res.computing       = compute_mode_next;
  end

  // Configuration: writes must arrive only while idle, which the block does not enforce; reset command drops the gate
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SKIP_ENABLE: cfg.skip_enable    <= cfg_data[0];
        CFG_SKIP_THRESH: cfg.skip_threshold <= cfg_data;
        CFG_CLOCK_GATE:  cfg.clock_gate     <= cfg_data[0];
        default: begin
        end
      endcase
    end else if (fire) begin
      cfg.clock_gate <= clock_gate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      overflow_seen  <= 1'b0;
      compute_mode   <= 1'b0;
      read_ptr       <= '0;
      write_ptr      <= '0;
      act_count      <= '0;
      low_fill_flag  <= 1'b0;
      high_fill_flag <= 1'b0;
      weight_banks[0] <= '0;
      weight_banks[1] <= '0;
      bank_valid     <= '0;
      selected_bank  <= 1'b0;
    end else if (fire) begin
      accumulator    <= accumulator_next;
      overflow_seen  <= overflow_seen_next;
      compute_mode   <= compute_mode_next;
      read_ptr       <= read_ptr_next;
      write_ptr      <= write_ptr_next;
      act_count      <= act_count_next;
      low_fill_flag  <= low_fill_flag_next;
      high_fill_flag <= high_fill_flag_next;
      weight_banks[0] <= bank0_next;
      weight_banks[1] <= bank1_next;
      bank_valid     <= bank_valid_next;
      selected_bank  <= selected_bank_next;
    end
  end

  // Entries are only read after being written, so the store needs no reset
  always_ff @(posedge clk) begin
    if (fire && push_en) begin
      act_store[write_ptr] <= cmd.act_value;
    end
  end

endmodule

// ----- rtl/core/int8_mac_pe_with_zero_skip.sv -----
// int8 multiply-accumulate processing element with zero-skip.
//
// Input channel (in_valid/in_ready/in_data) carries one command per transfer:
// FIFO push/pop, weight loads, bank swap, FIFO or direct MAC, accumulator
// write/clear, or a PE reset. Every command yields exactly one result on the
// output channel (out_valid/out_ready/out_data), in command order.
// Configuration (zero-skip enable, skip threshold, clock gate) is written via
// cfg_we/cfg_index/cfg_data only while the PE is idle; the PE does not enforce this.
//
// A transferred command is held in the input register, then one pass of the
// MAC/FIFO logic writes its result into the result register, from which the
// result can transfer. The PE takes one command per cycle while the receiver
// does not stall; the 8x8 multiply plus the 33-bit accumulate in the execute
// pass sets the clock rate.
// Stall: when the receiver holds out_ready low, the result register holds
// its value, one more command waits in the input register, then in_ready
// drops until the result transfers.
// Reset (rst, synchronous): both registers empty, accumulator, flags, FIFO,
// weight banks and configuration cleared. Ready to take a command next cycle.
module int8_mac_pe_with_zero_skip (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  i8mac_pkg::cmd_t                in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output i8mac_pkg::res_t                out_data,
  input  logic                           cfg_we,
  input  logic [i8mac_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [i8mac_pkg::CfgDataW-1:0] cfg_data
);
  import i8mac_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  res_t res;
  logic advance;

  // Execute the held command when the result register is free or draining
  assign advance = cmd_valid && (!out_valid || out_ready);

  i8mac_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .advance   (advance),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // State update and result compute happen in one pass on advance
  i8mac_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res       (res)
  );

  // Result register: load on advance, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

// ----- rtl/core/i8mac_checker.sv -----
module i8mac_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            out_valid,
  input  logic            out_ready,
  input  i8mac_pkg::res_t out_data
);
  import i8mac_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A wrap in this step must be reflected in the sticky flag, and a step never both overflows and underflows
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.step_overflow || out_data.step_underflow)
      |-> out_data.sticky_overflow && !(out_data.step_overflow && out_data.step_underflow))
    else $error("wrap flags inconsistent");

  // A skipped MAC is a bubble and raises no wrap flag
  a_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.skipped
      |-> out_data.bubble && !out_data.step_overflow && !out_data.step_underflow)
    else $error("skipped MAC did work");

  // Fill never exceeds depth
  a_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.fifo_fill <= CntW'(FifoDepth))
    else $error("FIFO fill out of range");

endmodule

bind int8_mac_pe_with_zero_skip i8mac_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- verif/int8_mac_pe_with_zero_skip_tb.sv -----
module int8_mac_pe_with_zero_skip_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i8mac_pkg::*;

  // Modes above the reset command do nothing but report the current state.
  localparam int ModeNopLo = 10;
  localparam int ModeNopHi = 15;
  // The configuration index that maps to no register at all.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // Transfer-free cycles tolerated before the run is declared hung. The slowest
  // legal stretch is the long receiver hold-off set by LongHold.
  localparam int LongHold   = 80;
  localparam int StallLimit = 1000;
  localparam int ItemsPerPhase = 128;
  localparam int NumPhases     = 10;

  // Tracks the PE state, predicts the result of every accepted command and
  // checks the results that come back, in command order.
  class mac_result_board;
    res_t pending_results[$];
    int   mismatches;

    bit                 skip_on;
    logic signed [7:0]  skip_thresh;
    bit                 gate;

    logic signed [31:0] acc;
    bit                 sticky;
    bit                 compute;
    logic signed [7:0]  act_fifo[FifoDepth];
    logic [PtrW-1:0]    rd_ptr;
    logic [PtrW-1:0]    wr_ptr;
    logic [CntW-1:0]    fill;
    bit                 low_flag;
    bit                 high_flag;
    logic signed [7:0]  bank_w[2];
    bit                 bank_ok[2];
    bit                 sel_bank;

    function new();
      mismatches  = 0;
      skip_on     = 0;
      skip_thresh = '0;
      gate        = 0;
      clear_pe();
    endfunction

    function void clear_pe();
      acc        = '0;
      sticky     = 0;
      compute    = 0;
      foreach (act_fifo[i]) act_fifo[i] = '0;
      rd_ptr     = '0;
      wr_ptr     = '0;
      fill       = '0;
      low_flag   = 0;
      high_flag  = 0;
      bank_w[0]  = '0;
      bank_w[1]  = '0;
      bank_ok[0] = 0;
      bank_ok[1] = 0;
      sel_bank   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SKIP_ENABLE: skip_on     = data[0];
        CFG_SKIP_THRESH: skip_thresh = data;
        CFG_CLOCK_GATE:  gate        = data[0];
        default: ;
      endcase
    endfunction

    function void refresh_flags();
      low_flag  = (fill <= 2);
      high_flag = (fill + 2 >= FifoDepth);
    endfunction

    function void run_mac(int a, int w, bit check, inout res_t r);
      int     thr;
      longint sum;
      if (gate || !compute) begin
        r.bubble = 1;
        return;
      end
      if (check && skip_on) begin
        thr = skip_thresh;
        if (a == 0 || (thr != 0 && a < thr && a > -thr)) begin
          r.skipped = 1;
          r.bubble  = 1;
          return;
        end
      end
      sum = longint'(acc) + longint'(a * w);
      if (sum > longint'(32'sh7fffffff)) begin
        r.step_overflow = 1;
        sticky = 1;
      end
      if (sum < longint'(32'sh80000000)) begin
        r.step_underflow = 1;
        sticky = 1;
      end
      acc = sum[31:0];
    endfunction

    function res_t next_result(cmd_t c);
      res_t r;
      int   a;
      int   w;
      r = '0;
      case (c.mode)
        MODE_PUSH: begin
          if (fill < FifoDepth) begin
            act_fifo[wr_ptr] = c.act_value;
            wr_ptr = wr_ptr + 1'b1;
            fill   = fill + 1'b1;
            refresh_flags();
          end
        end
        MODE_POP: begin
          if (fill != 0) begin
            r.popped_value = act_fifo[rd_ptr];
            rd_ptr = rd_ptr + 1'b1;
            fill   = fill - 1'b1;
            refresh_flags();
          end
        end
        MODE_LOAD_W: begin
          bank_w[sel_bank]  = c.weight_a;
          bank_ok[sel_bank] = 1;
          compute = 1;
        end
        MODE_LOAD_PAIR: begin
          bank_w[0]  = c.weight_a;
          bank_w[1]  = c.weight_b;
          bank_ok[0] = 1;
          bank_ok[1] = 1;
          sel_bank   = 0;
          compute    = 1;
        end
        MODE_SWAP: sel_bank = ~sel_bank;
        MODE_MAC_FIFO: begin
          // The head is only read; an empty FIFO or dead bank reads as zero.
          if (fill != 0) a = act_fifo[rd_ptr];
          else a = 0;
          if (bank_ok[sel_bank]) w = bank_w[sel_bank];
          else w = 0;
          run_mac(a, w, c.skip_test, r);
        end
        MODE_MAC_DIRECT: run_mac(c.act_value, c.weight_a, skip_on, r);
        MODE_WRITE_ACC:  acc = c.acc_value;
        MODE_CLEAR_ACC:  acc = '0;
        MODE_RESET: begin
          clear_pe();
          gate = 0;
        end
        default: ;
      endcase
      r.acc_out         = acc;
      r.sticky_overflow = sticky;
      r.fifo_fill       = fill;
      r.low_fill        = low_flag;
      r.high_fill       = high_flag;
      r.weight_ready    = bank_ok[sel_bank];
      r.computing       = compute;
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending_results.push_back(next_result(c));
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report_mismatch(string msg);
      // Keep the log short when the design is badly off.
      if (mismatches < 40) $display("%0t: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string field, longint got, longint want);
      if (got != want)
        report_mismatch($sformatf("%s: got %0d, expected %0d", field, got, want));
    endtask

    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no command outstanding");
        return;
      end
      want = pending_results.pop_front();
      compare_field("acc_out", got.acc_out, want.acc_out);
      compare_field("step_overflow", got.step_overflow, want.step_overflow);
      compare_field("step_underflow", got.step_underflow, want.step_underflow);
      compare_field("sticky_overflow", got.sticky_overflow, want.sticky_overflow);
      compare_field("skipped", got.skipped, want.skipped);
      compare_field("bubble", got.bubble, want.bubble);
      compare_field("popped_value", got.popped_value, want.popped_value);
      compare_field("fifo_fill", got.fifo_fill, want.fifo_fill);
      compare_field("low_fill", got.low_fill, want.low_fill);
      compare_field("high_fill", got.high_fill, want.high_fill);
      compare_field("weight_ready", got.weight_ready, want.weight_ready);
      compare_field("computing", got.computing, want.computing);
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  cmd_t                in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  res_t                out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  mac_result_board board = new();

  // Set by the stimulus, consumed by the receiver process.
  bit long_hold_req = 0;
  // Last phase: run both sides flat out.
  bit quiet = 0;
  int idle_cycles = 0;

  int8_mac_pe_with_zero_skip DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Offer one command and hold it until the transfer. Call at a rising edge;
  // returns at the edge of the transfer, so back-to-back calls keep valid high.
  task automatic send_cmd(cmd_t c);
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_command(c);
  endtask

  // Drop valid for a random burst now and then, except in the quiet phase.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write all registers back to back while the PE is idle. The upper data bits
  // of the one-bit registers carry noise, and the unused index gets a write too.
  task automatic apply_settings(bit zse, logic [7:0] thr, bit gate_on);
    logic [CfgDataW-1:0] d;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SKIP_ENABLE;
    d = {7'($urandom), zse};
    cfg_data  <= d;
    board.write_reg(CFG_SKIP_ENABLE, d);
    @(posedge clk);
    cfg_index <= CFG_SKIP_THRESH;
    cfg_data  <= thr;
    board.write_reg(CFG_SKIP_THRESH, thr);
    @(posedge clk);
    cfg_index <= CFG_CLOCK_GATE;
    d = {7'($urandom), gate_on};
    cfg_data  <= d;
    board.write_reg(CFG_CLOCK_GATE, d);
    @(posedge clk);
    cfg_index <= CfgUnused;
    d = 8'($urandom);
    cfg_data  <= d;
    board.write_reg(CfgUnused, d);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic cmd_t cmd_of(logic [3:0] mode, logic [7:0] act, logic [7:0] wa,
                                  logic [7:0] wb, bit chk, logic [31:0] accv);
    cmd_t c;
    c.mode      = mode;
    c.act_value = act;
    c.weight_a  = wa;
    c.weight_b  = wb;
    c.skip_test = chk;
    c.acc_value = accv;
    return c;
  endfunction

  // Mostly MAC and FIFO traffic with live weights; resets and no-ops are rare so
  // the PE stays in compute for long runs. Activations lean toward zero and the
  // threshold band, accumulator writes toward the wrap points.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if      (pick < 18) c.mode = MODE_PUSH;
    else if (pick < 28) c.mode = MODE_POP;
    else if (pick < 35) c.mode = MODE_LOAD_W;
    else if (pick < 40) c.mode = MODE_LOAD_PAIR;
    else if (pick < 45) c.mode = MODE_SWAP;
    else if (pick < 67) c.mode = MODE_MAC_FIFO;
    else if (pick < 85) c.mode = MODE_MAC_DIRECT;
    else if (pick < 91) c.mode = MODE_WRITE_ACC;
    else if (pick < 95) c.mode = MODE_CLEAR_ACC;
    else if (pick < 96) c.mode = MODE_RESET;
    else c.mode = 4'($urandom_range(ModeNopLo, ModeNopHi));

    pick = $urandom_range(0, 9);
    if (pick < 2) c.act_value = '0;
    else if (pick < 5) c.act_value = 8'($urandom_range(0, 10) - 5);
    else if (pick < 6) c.act_value = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
    else c.act_value = 8'($urandom);

    if ($urandom_range(0, 3) == 0) c.weight_a = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
    else c.weight_a = 8'($urandom);
    c.weight_b  = 8'($urandom);
    c.skip_test = 1'($urandom);

    pick = $urandom_range(0, 3);
    if (pick == 0) c.acc_value = 32'h7fff_ffff - $urandom_range(0, 40000);
    else if (pick == 1) c.acc_value = 32'h8000_0000 + $urandom_range(0, 40000);
    else c.acc_value = $urandom;
    return c;
  endfunction

  // Check every result that transfers.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  // Hang detection: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == StallLimit) begin
      $display("[int8_mac_pe_with_zero_skip] ERROR");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none at the end.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        // Hold long enough that the PE fills and pushes back on the sender.
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        out_ready <= 1'b1;
        long_hold_req = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle bubbles, empty-FIFO pop, weight load, FIFO overfill,
    // dead bank after swap, pair load, wrap both ways, clear, no-op, reset.
    send_cmd(cmd_of(MODE_MAC_DIRECT, 8'sd5, 8'sd7, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_MAC_FIFO, '0, '0, '0, 1'b1, '0));
    send_cmd(cmd_of(MODE_POP, '0, '0, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_LOAD_W, '0, 8'sd127, 8'sd1, 1'b0, '0));
    send_cmd(cmd_of(MODE_MAC_DIRECT, 8'sd127, 8'sd127, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_PUSH, -8'sd128, '0, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_PUSH, 8'sd127, '0, '0, 1'b0, '0));
    for (int i = 0; i < 7; i++) begin
      // The last of these lands on a full FIFO and must be dropped.
      send_cmd(cmd_of(MODE_PUSH, 8'(i - 3), '0, '0, 1'b0, '0));
      sender_gap();
    end
    send_cmd(cmd_of(MODE_MAC_FIFO, '0, '0, '0, 1'b1, '0));
    send_cmd(cmd_of(MODE_SWAP, '0, '0, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_MAC_FIFO, '0, '0, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_LOAD_PAIR, '0, -8'sd128, 8'sd127, 1'b0, '0));
    send_cmd(cmd_of(MODE_WRITE_ACC, '0, '0, '0, 1'b0, 32'h7fff_ffff));
    send_cmd(cmd_of(MODE_MAC_DIRECT, 8'sd127, 8'sd127, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_WRITE_ACC, '0, '0, '0, 1'b0, 32'h8000_0000));
    send_cmd(cmd_of(MODE_MAC_DIRECT, -8'sd128, 8'sd127, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_POP, '0, '0, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_POP, '0, '0, '0, 1'b0, '0));
    send_cmd(cmd_of(MODE_CLEAR_ACC, '0, '0, '0, 1'b0, 32'hffff_ffff));
    send_cmd(cmd_of(4'(ModeNopHi), 8'hff, 8'hff, 8'hff, 1'b1, 32'hffff_ffff));
    send_cmd(cmd_of(MODE_RESET, '0, '0, '0, 1'b0, '0));

    // Random phases, each under its own register settings. Threshold extremes,
    // a negative band and the clock gate come first, then random settings.
    for (int p = 0; p < NumPhases; p++) begin
      drain();
      case (p)
        0: apply_settings(1'b1, 8'sd0, 1'b0);
        1: apply_settings(1'b1, 8'sd4, 1'b0);
        2: apply_settings(1'b1, -8'sd128, 1'b0);
        3: apply_settings(1'b1, 8'sd127, 1'b0);
        4: apply_settings(1'b0, 8'sd3, 1'b1);
        5: apply_settings(1'b1, -8'sd3, 1'b0);
        6: apply_settings(1'b1, 8'sd1, 1'b1);
        default: apply_settings(1'($urandom),
                                $urandom_range(0, 1) ? 8'($urandom_range(0, 8)) : 8'($urandom),
                                $urandom_range(0, 3) == 0);
      endcase
      if (p == 2) long_hold_req = 1;
      if (p == NumPhases - 1) quiet = 1;
      // Open with a pair load so MACs execute from the start of the phase unless the clock gate is on.
      send_cmd(cmd_of(MODE_LOAD_PAIR, '0, 8'($urandom), 8'($urandom), 1'b0, '0));
      repeat (ItemsPerPhase) begin
        send_cmd(random_cmd());
        sender_gap();
      end
    end

    drain();
    // Give the pipeline time to show any stray result.
    repeat (6) @(posedge clk);
    if (board.mismatches == 0) $display("[int8_mac_pe_with_zero_skip] OK");
    else $display("[int8_mac_pe_with_zero_skip] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/i8mac_pkg.sv
rtl/core/i8mac_in_reg.sv
rtl/core/i8mac_core.sv
rtl/core/int8_mac_pe_with_zero_skip.sv
rtl/core/i8mac_checker.sv
verif/int8_mac_pe_with_zero_skip_tb.sv
